/* sv/macd_crossover_tracker_core_defines.svh */
// Assertion macros used by the port-level checker macd_checker of the MACD tracker.
// Depends on nothing; the using scope must provide clk and rst_n.
`ifndef MACD_CROSSOVER_TRACKER_CORE_DEFINES_SVH
`define MACD_CROSSOVER_TRACKER_CORE_DEFINES_SVH

// Implication checked at every rising edge outside reset.
`define MACD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define MACD_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* sv/macd_pkg.sv */
// Shared constants, types and helper functions of the MACD tracker.
// Depends on nothing; used by macd_div and macd_crossover_tracker_core.
`default_nettype none
package macd_pkg;

  localparam int PRICE_W   = 32;
  localparam int ACC_W     = 48;
  localparam int NUM_W     = ACC_W + 2;
  localparam int VAL_W     = 32;
  localparam int PER_W     = 7;
  localparam int CNT_W     = 8;
  localparam int DIV_W     = 64;
  localparam int DEN_W     = 32;
  localparam int DIV_CW    = $clog2(DIV_W);
  localparam int PCT_SHIFT = 24;
  localparam int PCT_MUL_W = 7;
  localparam int PROD_W    = VAL_W + PCT_MUL_W;
  localparam int REG_IDX_W = 2;
  localparam int PER_MAX   = 64;

  localparam logic [PCT_MUL_W-1:0] PCT_SCALE = PCT_MUL_W'(100);

  localparam logic [REG_IDX_W-1:0] REG_FAST   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SLOW   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SIGNAL = 2'd2;

  localparam logic [PER_W-1:0] FAST_RST   = PER_W'(12);
  localparam logic [PER_W-1:0] SLOW_RST   = PER_W'(26);
  localparam logic [PER_W-1:0] SIGNAL_RST = PER_W'(9);

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DEN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  // Zero is used as one and anything above the maximum as the maximum.
  function automatic logic [PER_W-1:0] clamp_period(input logic [PER_W-1:0] p);
    logic [PER_W-1:0] r;
    if (p == '0) r = PER_W'(1);
    else if (p > PER_W'(PER_MAX)) r = PER_W'(PER_MAX);
    else r = p;
    return r;
  endfunction

  // Saturates a wide signed value to the 32-bit result range.
  function automatic logic [VAL_W-1:0] sat_val(input logic [ACC_W:0] v);
    logic [VAL_W-1:0] r;
    if (v[ACC_W:VAL_W-1] == '0 || v[ACC_W:VAL_W-1] == '1) r = v[VAL_W-1:0];
    else if (v[ACC_W]) r = {1'b1, {(VAL_W-1){1'b0}}};
    else r = {1'b0, {(VAL_W-1){1'b1}}};
    return r;
  endfunction

endpackage
`default_nettype wire

/* sv/macd_div.sv */
// Bit-serial restoring divider, one quotient bit per clock.
// Depends on macd_pkg for widths and the request/response structs.
`default_nettype none
module macd_div
  import macd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [DEN_W-1:0]  rem_r;
  logic [DIV_W-1:0]  quo_r;
  logic [DEN_W-1:0]  den_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DEN_W:0] trial;
  logic [DEN_W:0] diff;
  logic           ge;

  assign trial = {rem_r, quo_r[DIV_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + DIV_CW'(1);
      if (cnt_r == DIV_CW'(DIV_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // The dividend shifts out of the top of quo_r as quotient bits shift in.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      den_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire

/* sv/macd_crossover_tracker_core.sv */
// Top level of the MACD crossover tracker: sequencer, averages and result register.
// Depends on macd_pkg and the serial divider macd_div.
`default_nettype none
// The tracker takes one closing price (unsigned Q16.16) per input transaction and
// returns one result transaction with the MACD line, its signal line, crossover
// flags and both lines as a percentage of the close (signed Q8.24). The fast and
// slow averages are seeded with the rounded mean of their first samples and then
// follow the exponential update with weight 2/(period+1); the signal line does the
// same on the MACD line. Items are handled one at a time. Every rounded division
// goes through a single shared divider that produces one quotient bit per clock;
// an item needs up to five divisions (fast, slow, signal, two percentages),
// depending on where the series stands. A finished result sits in an output
// register, so the next item can be accepted while it waits. Periods are to be
// written through the configuration port only while the block is idle; the block
// itself does not enforce it, and the port is always ready.
module macd_crossover_tracker_core
  import macd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [REG_IDX_W-1:0]  cfg_index,
  input  wire logic [PER_W-1:0]      cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_series_start,
  input  wire logic [PRICE_W-1:0]    in_close_price,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_ready_res,
  output logic signed [VAL_W-1:0]    out_macd_value,
  output logic signed [VAL_W-1:0]    out_signal_value,
  output logic                       out_cross_up,
  output logic                       out_cross_down,
  output logic signed [VAL_W-1:0]    out_macd_percent,
  output logic signed [VAL_W-1:0]    out_signal_percent,
  output logic                       out_percent_valid
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_AVG  = 4'd1;
  localparam logic [3:0] S_AVGW = 4'd2;
  localparam logic [3:0] S_MACD = 4'd3;
  localparam logic [3:0] S_SIGV = 4'd4;
  localparam logic [3:0] S_FLAG = 4'd5;
  localparam logic [3:0] S_PW1  = 4'd6;
  localparam logic [3:0] S_PS   = 4'd7;
  localparam logic [3:0] S_PW2  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  localparam logic [1:0] SEL_FAST = 2'd0;
  localparam logic [1:0] SEL_SLOW = 2'd1;
  localparam logic [1:0] SEL_SIG  = 2'd2;

  // Configuration registers.
  logic [PER_W-1:0] fast_per_r, slow_per_r, sig_per_r;

  // Per-item working state.
  logic [3:0]         state_r, state_nxt;
  logic [1:0]         sel_r;
  logic [PRICE_W-1:0] close_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [PER_W-1:0]   pf_r, ps_r, pg_r;
  logic               seed_r, neg_r;

  // Series state.
  logic signed [ACC_W-1:0] fast_acc_r, slow_acc_r, sig_acc_r;
  logic signed [VAL_W-1:0] macd_r, sig_r, prev_macd_r, prev_sig_r;
  logic [VAL_W-1:0]        mp_r, sp_r;
  logic                    rdy_r, bull_r, bear_r, pv_r;

  // Result register.
  logic                    out_valid_r;
  logic                    o_rdy_r, o_bull_r, o_bear_r, o_pv_r;
  logic signed [VAL_W-1:0] o_macd_r, o_sig_r, o_mp_r, o_sp_r;

  div_req_t div_req;
  div_rsp_t div_rsp;

  macd_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (div_req),
    .rsp  (div_rsp)
  );

  logic in_acc;
  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;

  // Clamped periods; the fast period never exceeds the slow one.
  logic [PER_W-1:0] ps_c, pf_c, pg_c;
  always_comb begin
    ps_c = clamp_period(slow_per_r);
    pf_c = clamp_period(fast_per_r);
    pg_c = clamp_period(sig_per_r);
    if (pf_c > ps_c) pf_c = ps_c;
  end

  // Sample count after this item, saturating.
  logic [CNT_W-1:0] cnt_base, cnt_nxt;
  assign cnt_base = in_series_start ? '0 : cnt_r;
  assign cnt_nxt  = (cnt_base == '1) ? cnt_base : cnt_base + CNT_W'(1);

  // Position in the MACD series, valid once count has reached the slow period.
  logic [CNT_W-1:0] sig_pos;
  assign sig_pos = cnt_r - CNT_W'(ps_r) + CNT_W'(1);

  // Averaging step, shared by the three averages and selected by sel_r.
  logic signed [ACC_W-1:0] acc_cur, x_cur, sum;
  logic [CNT_W-1:0]        pos_cur, per_cur;
  logic                    seed_ph, need_div;
  logic signed [ACC_W:0]   diff;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0]        mag;
  logic [CNT_W-1:0]        den;
  logic [DIV_W-1:0]        avg_dividend;

  always_comb begin
    case (sel_r)
      SEL_FAST: begin
        acc_cur = fast_acc_r;
        per_cur = CNT_W'(pf_r);
      end
      SEL_SLOW: begin
        acc_cur = slow_acc_r;
        per_cur = CNT_W'(ps_r);
      end
      default: begin
        acc_cur = sig_acc_r;
        per_cur = CNT_W'(pg_r);
      end
    endcase
    if (sel_r == SEL_SIG) begin
      x_cur   = {{(ACC_W-VAL_W){macd_r[VAL_W-1]}}, macd_r};
      pos_cur = sig_pos;
    end else begin
      x_cur   = $signed({{(ACC_W-PRICE_W){1'b0}}, close_r});
      pos_cur = cnt_r;
    end
    seed_ph  = pos_cur <= per_cur;
    need_div = seed_ph ? (pos_cur == per_cur) : 1'b1;
    sum      = acc_cur + x_cur;
    diff     = {x_cur[ACC_W-1], x_cur} - {acc_cur[ACC_W-1], acc_cur};
    num      = seed_ph ? {{2{sum[ACC_W-1]}}, sum} : {diff, 1'b0};
    den      = seed_ph ? per_cur : per_cur + CNT_W'(1);
    mag      = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    avg_dividend = DIV_W'(mag) + DIV_W'(den >> 1);
  end

  // Result of the rounded division, signed and wrapped to the accumulator.
  logic [DIV_W-1:0]        q_signed;
  logic signed [ACC_W-1:0] acc_div_res;
  assign q_signed    = neg_r ? DIV_W'(-div_rsp.quotient) : div_rsp.quotient;
  assign acc_div_res = seed_r ? $signed(q_signed[ACC_W-1:0])
                              : acc_cur + $signed(q_signed[ACC_W-1:0]);

  // Percentage of the close: |value| * 100 * 2^24 + close/2, divided by close.
  logic [VAL_W-1:0]  pct_src, pct_mag;
  logic [PROD_W-1:0] pct_prod;
  logic [DIV_W-1:0]  pct_dividend;
  logic              pct_neg;
  logic [VAL_W-1:0]  pct_res;
  assign pct_src      = (state_r == S_PS) ? sig_r : macd_r;
  assign pct_mag      = pct_src[VAL_W-1] ? VAL_W'(-pct_src) : pct_src;
  assign pct_prod     = PROD_W'(pct_mag) * PROD_W'(PCT_SCALE);
  assign pct_dividend = DIV_W'({pct_prod, {PCT_SHIFT{1'b0}}}) + DIV_W'(close_r >> 1);
  assign pct_neg      = (state_r == S_PW2) ? sig_r[VAL_W-1] : macd_r[VAL_W-1];

  always_comb begin
    if (pct_neg) begin
      if (div_rsp.quotient > (DIV_W'(1) << (VAL_W - 1))) pct_res = {1'b1, {(VAL_W-1){1'b0}}};
      else pct_res = VAL_W'(-div_rsp.quotient);
    end else begin
      if (div_rsp.quotient > DIV_W'({1'b0, {(VAL_W-1){1'b1}}}))
        pct_res = {1'b0, {(VAL_W-1){1'b1}}};
      else pct_res = div_rsp.quotient[VAL_W-1:0];
    end
  end

  // Flags of the current item.
  logic [CNT_W-1:0] ready_lim;
  logic             ready_c, pvalid_c;
  assign ready_lim = CNT_W'(ps_r) + CNT_W'(pg_r) + CNT_W'(1);
  assign ready_c   = cnt_r >= ready_lim;
  assign pvalid_c  = ready_c && (close_r != '0);

  // One request source at a time drives the divider.
  always_comb begin
    div_req.start    = ((state_r == S_AVG) && need_div) ||
                       ((state_r == S_FLAG) && pvalid_c) || (state_r == S_PS);
    div_req.dividend = (state_r == S_AVG) ? avg_dividend : pct_dividend;
    div_req.divisor  = (state_r == S_AVG) ? DEN_W'(den) : DEN_W'(close_r);
  end

  // Accumulator write, either directly from the running sum or after a division.
  logic                    acc_wen;
  logic signed [ACC_W-1:0] acc_wdata;
  always_comb begin
    acc_wen   = 1'b0;
    acc_wdata = sum;
    if (state_r == S_AVG && !need_div) begin
      acc_wen = 1'b1;
    end else if (state_r == S_AVGW && div_rsp.done) begin
      acc_wen   = 1'b1;
      acc_wdata = acc_div_res;
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_acc) state_nxt = S_AVG;
      S_AVG: begin
        if (need_div) state_nxt = S_AVGW;
        else if (sel_r == SEL_FAST) state_nxt = S_AVG;
        else if (sel_r == SEL_SLOW) state_nxt = S_MACD;
        else state_nxt = S_SIGV;
      end
      S_AVGW: begin
        if (div_rsp.done) begin
          if (sel_r == SEL_FAST) state_nxt = S_AVG;
          else if (sel_r == SEL_SLOW) state_nxt = S_MACD;
          else state_nxt = S_SIGV;
        end
      end
      S_MACD: state_nxt = (cnt_r >= CNT_W'(ps_r)) ? S_AVG : S_FLAG;
      S_SIGV: state_nxt = S_FLAG;
      S_FLAG: state_nxt = pvalid_c ? S_PW1 : S_OUT;
      S_PW1:  if (div_rsp.done) state_nxt = S_PS;
      S_PS:   state_nxt = S_PW2;
      S_PW2:  if (div_rsp.done) state_nxt = S_OUT;
      S_OUT:  if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      fast_per_r <= FAST_RST;
      slow_per_r <= SLOW_RST;
      sig_per_r  <= SIGNAL_RST;
      cnt_r      <= '0;
      fast_acc_r <= '0;
      slow_acc_r <= '0;
      sig_acc_r  <= '0;
      prev_macd_r <= '0;
      prev_sig_r  <= '0;
      out_valid_r <= 1'b0;
      sel_r       <= SEL_FAST;
    end else begin
      state_r <= state_nxt;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_FAST:   fast_per_r <= cfg_data;
          REG_SLOW:   slow_per_r <= cfg_data;
          REG_SIGNAL: sig_per_r  <= cfg_data;
          default: ;
        endcase
      end

      // A new result may replace one that is taken at the same edge.
      if (state_r == S_OUT && state_nxt == S_IDLE) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      if (in_acc) begin
        cnt_r <= cnt_nxt;
        sel_r <= SEL_FAST;
        if (in_series_start) begin
          fast_acc_r  <= '0;
          slow_acc_r  <= '0;
          sig_acc_r   <= '0;
          prev_macd_r <= '0;
          prev_sig_r  <= '0;
        end
      end

      if (acc_wen) begin
        case (sel_r)
          SEL_FAST: fast_acc_r <= acc_wdata;
          SEL_SLOW: slow_acc_r <= acc_wdata;
          default:  sig_acc_r  <= acc_wdata;
        endcase
        if (sel_r == SEL_FAST) sel_r <= SEL_SLOW;
      end

      if (state_r == S_MACD && cnt_r >= CNT_W'(ps_r)) sel_r <= SEL_SIG;

      if (state_r == S_FLAG) begin
        prev_macd_r <= macd_r;
        prev_sig_r  <= sig_r;
      end
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      close_r <= in_close_price;
      pf_r    <= pf_c;
      ps_r    <= ps_c;
      pg_r    <= pg_c;
    end
    if (state_r == S_AVG && need_div) begin
      seed_r <= seed_ph;
      neg_r  <= num[NUM_W-1];
    end
    if (state_r == S_MACD) begin
      sig_r <= '0;
      if (cnt_r >= CNT_W'(ps_r))
        macd_r <= $signed(sat_val({fast_acc_r[ACC_W-1], fast_acc_r} -
                                  {slow_acc_r[ACC_W-1], slow_acc_r}));
      else
        macd_r <= '0;
    end
    if (state_r == S_SIGV) begin
      if (sig_pos >= CNT_W'(pg_r))
        sig_r <= $signed(sat_val({sig_acc_r[ACC_W-1], sig_acc_r}));
      else
        sig_r <= '0;
    end
    if (state_r == S_FLAG) begin
      rdy_r  <= ready_c;
      bull_r <= ready_c && (prev_macd_r <= prev_sig_r) && (macd_r > sig_r);
      bear_r <= ready_c && (prev_macd_r >= prev_sig_r) && (macd_r < sig_r);
      pv_r   <= pvalid_c;
      mp_r   <= '0;
      sp_r   <= '0;
    end
    if (state_r == S_PW1 && div_rsp.done) mp_r <= pct_res;
    if (state_r == S_PW2 && div_rsp.done) sp_r <= pct_res;
    if (state_r == S_OUT && state_nxt == S_IDLE) begin
      o_rdy_r  <= rdy_r;
      o_macd_r <= macd_r;
      o_sig_r  <= sig_r;
      o_bull_r <= bull_r;
      o_bear_r <= bear_r;
      o_mp_r   <= $signed(mp_r);
      o_sp_r   <= $signed(sp_r);
      o_pv_r   <= pv_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_ready_res      = o_rdy_r;
  assign out_macd_value     = o_macd_r;
  assign out_signal_value   = o_sig_r;
  assign out_cross_up       = o_bull_r;
  assign out_cross_down     = o_bear_r;
  assign out_macd_percent   = o_mp_r;
  assign out_signal_percent = o_sp_r;
  assign out_percent_valid  = o_pv_r;

endmodule
`default_nettype wire

/* sv/macd_checker.sv */
// Port-level checker of the MACD tracker and its bind to the top level.
// Depends on macd_pkg and macd_crossover_tracker_core_defines.svh.
`default_nettype none
`include "macd_crossover_tracker_core_defines.svh"
module macd_checker
  import macd_pkg::*;
(
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic                 out_ready_res,
  input wire logic [VAL_W-1:0]     out_macd_value,
  input wire logic                 out_cross_up,
  input wire logic                 out_cross_down,
  input wire logic [VAL_W-1:0]     out_macd_percent,
  input wire logic [VAL_W-1:0]     out_signal_percent,
  input wire logic                 out_percent_valid
);

  `MACD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_macd_value), "result changed while stalled")
  `MACD_NEVER(a_both_cross, out_valid && out_cross_up && out_cross_down, "both crossovers set")
  `MACD_ASSERT(a_not_ready, out_valid && !out_ready_res |-> !out_cross_up && !out_cross_down && !out_percent_valid, "flags set before ready")
  `MACD_ASSERT(a_pct_zero, out_valid && !out_percent_valid |-> out_macd_percent == '0 && out_signal_percent == '0, "percent nonzero while invalid")
  `MACD_ASSERT(a_one_item, in_valid && in_ready |=> !in_ready, "second item taken while busy")

endmodule

bind macd_crossover_tracker_core macd_checker u_macd_checker (.*);
`default_nettype wire

/* verif/macd_tracker_checker.sv */
// Checker for the MACD crossover tracker: predicts every result from accepted
// input transactions and compares them with the result channel.
// Depends on macd_pkg for widths and register indexes.
`timescale 1ns / 100ps
module macd_tracker_checker
  import macd_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_valid,
  input  logic                     cfg_ready,
  input  logic [REG_IDX_W-1:0]     cfg_index,
  input  logic [PER_W-1:0]         cfg_data,
  input  logic                     in_valid,
  input  logic                     in_ready,
  input  logic                     in_series_start,
  input  logic [PRICE_W-1:0]       in_close_price,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     out_ready_res,
  input  logic signed [VAL_W-1:0]  out_macd_value,
  input  logic signed [VAL_W-1:0]  out_signal_value,
  input  logic                     out_cross_up,
  input  logic                     out_cross_down,
  input  logic signed [VAL_W-1:0]  out_macd_percent,
  input  logic signed [VAL_W-1:0]  out_signal_percent,
  input  logic                     out_percent_valid,
  output int                       fail_count,
  output int                       pending_count,
  output int                       result_count
);

  typedef struct packed {
    logic                    rdy;
    logic signed [VAL_W-1:0] macd;
    logic signed [VAL_W-1:0] sig;
    logic                    bull;
    logic                    bear;
    logic signed [VAL_W-1:0] mpct;
    logic signed [VAL_W-1:0] spct;
    logic                    pvalid;
  } macd_result_t;

  macd_result_t expected_results[$];

  logic [PER_W-1:0] fast_reg, slow_reg, sig_reg;
  int unsigned      samples;
  longint           fast_avg, slow_avg, sig_avg, last_macd, last_sig;

  function automatic longint wrap48(longint v);
    logic [ACC_W-1:0] t;
    t = v[ACC_W-1:0];
    return longint'($signed(t));
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint m;
    longint q;
    m = (num < 0) ? -num : num;
    q = (m + den / 2) / den;
    return (num < 0) ? -q : q;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic int unsigned eff_period(logic [PER_W-1:0] p);
    if (p == 0) return 1;
    if (p > 64) return 64;
    return p;
  endfunction

  // pos is the 1-based position of x within the series being averaged.
  function automatic longint ema_update(longint acc, longint x, int unsigned pos,
                                        int unsigned per);
    if (pos <= per) begin
      acc = wrap48(acc + x);
      if (pos == per) acc = round_div(acc, per);
      return acc;
    end
    return wrap48(acc + round_div(2 * (x - acc), per + 1));
  endfunction

  // Magnitude times 100 in Q8.24 can exceed 2^61; the product is computed unsigned.
  function automatic longint pct_of_close(longint v, longint unsigned cl);
    longint unsigned m, q;
    m = (v < 0) ? longint'(-v) : longint'(v);
    q = (m * 64'd100 * (64'd1 << 24) + cl / 2) / cl;
    if (v < 0) return (q > (64'd1 << 31)) ? -64'sd2147483648 : -longint'(q);
    return (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
  endfunction

  task automatic predict_result(logic start, logic [PRICE_W-1:0] price);
    int unsigned  pf, ps, pg, j;
    longint       cl, mv, sv;
    macd_result_t r;
    ps = eff_period(slow_reg);
    pf = eff_period(fast_reg);
    pg = eff_period(sig_reg);
    if (pf > ps) pf = ps;
    if (start) begin
      samples = 0; fast_avg = 0; slow_avg = 0; sig_avg = 0;
      last_macd = 0; last_sig = 0;
    end
    if (samples < 255) samples++;
    cl = longint'(price);
    mv = 0;
    sv = 0;
    fast_avg = ema_update(fast_avg, cl, samples, pf);
    slow_avg = ema_update(slow_avg, cl, samples, ps);
    if (samples >= ps) begin
      j = samples - ps + 1;
      mv = clip32(fast_avg - slow_avg);
      sig_avg = ema_update(sig_avg, mv, j, pg);
      if (j >= pg) sv = clip32(sig_avg);
    end
    r = '0;
    r.rdy = samples >= ps + pg + 1;
    r.macd = mv[VAL_W-1:0];
    r.sig = sv[VAL_W-1:0];
    if (r.rdy) begin
      r.bull = last_macd <= last_sig && mv > sv;
      r.bear = last_macd >= last_sig && mv < sv;
    end
    r.pvalid = r.rdy && price != 0;
    if (r.pvalid) begin
      r.mpct = pct_of_close(mv, cl);
      r.spct = pct_of_close(sv, cl);
    end
    last_macd = mv;
    last_sig = sv;
    expected_results.push_back(r);
  endtask

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endtask

  assign pending_count = expected_results.size();

  always @(posedge clk) begin
    macd_result_t e;
    if (!rst_n) begin
      fast_reg <= FAST_RST;
      slow_reg <= SLOW_RST;
      sig_reg <= SIGNAL_RST;
      samples = 0; fast_avg = 0; slow_avg = 0; sig_avg = 0;
      last_macd = 0; last_sig = 0;
      expected_results.delete();
      fail_count = 0;
      result_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FAST:   fast_reg <= cfg_data;
          REG_SLOW:   slow_reg <= cfg_data;
          REG_SIGNAL: sig_reg <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_result(in_series_start, in_close_price);
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (expected_results.size() == 0) begin
          fail_count++;
          $display("%0t: result transaction with no expectation waiting", $time);
        end else begin
          e = expected_results.pop_front();
          check_field("ready_res", e.rdy, out_ready_res);
          check_field("macd_value", e.macd, out_macd_value);
          check_field("signal_value", e.sig, out_signal_value);
          check_field("cross_up", e.bull, out_cross_up);
          check_field("cross_down", e.bear, out_cross_down);
          check_field("macd_percent", e.mpct, out_macd_percent);
          check_field("signal_percent", e.spct, out_signal_percent);
          check_field("percent_valid", e.pvalid, out_percent_valid);
        end
      end
    end
  end

endmodule

/* verif/tb_macd_crossover_tracker_core.sv */
// Testbench top for the MACD crossover tracker: drives prices, periods and
// back-pressure; depends on macd_pkg, the block and macd_tracker_checker.
`timescale 1ns / 100ps
module tb_macd_crossover_tracker_core;
  import macd_pkg::*;

  // Quiet cycles tolerated before the run is declared hung.
  localparam int HANG_LIMIT = 20000;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [REG_IDX_W-1:0]    cfg_index = REG_FAST;
  logic [PER_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_series_start = 1'b0;
  logic [PRICE_W-1:0]      in_close_price = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    out_ready_res;
  logic signed [VAL_W-1:0] out_macd_value, out_signal_value;
  logic                    out_cross_up, out_cross_down;
  logic signed [VAL_W-1:0] out_macd_percent, out_signal_percent;
  logic                    out_percent_valid;

  int fail_count, pending_count, result_count;

  // Idle percentages for the sender and the receiver; the stimulus process
  // changes them from phase to phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_receiver = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned items_sent = 0;
  int unsigned series_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  macd_crossover_tracker_core uut (.*);

  macd_tracker_checker checker_i (.*);

  // The receiver stalls at random, or is held off entirely during the
  // pressure phase so that the block fills up and stops taking input.
  always @(posedge clk) begin
    if (!rst_n || hold_receiver) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog: any transaction on any channel restarts the quiet count.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", pending_count);
      $display("** macd_crossover_tracker_core: FAILED **");
      $finish;
    end
  end

  // Sends one price transaction, with a random idle gap before it. Valid is
  // left high after acceptance so that back-to-back items need no gap; it is
  // dropped before an idle gap or when the stimulus drains the block.
  task automatic send_price(bit start, logic [PRICE_W-1:0] price);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_series_start <= start;
    in_close_price <= price;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    if (start) series_count++;
  endtask

  // Writes one period register; only called once the block has drained.
  task automatic write_period(logic [REG_IDX_W-1:0] idx, logic [PER_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_periods(int unsigned f, int unsigned s, int unsigned g);
    wait_drained();
    write_period(REG_FAST, PER_W'(f));
    write_period(REG_SLOW, PER_W'(s));
    write_period(REG_SIGNAL, PER_W'(g));
    cfg_valid <= 1'b0;
  endtask

  // Prices wander around a level so the averages cross now and then; a few
  // items jump to extreme or zero closes.
  function automatic logic [PRICE_W-1:0] next_price(logic [PRICE_W-1:0] p);
    int unsigned pick;
    longint      step;
    pick = $urandom_range(99);
    if (pick < 3) return '0;
    if (pick < 6) return '1;
    if (pick < 10) return $urandom();
    step = longint'($urandom_range(32'h0008_0000)) - 64'sh4_0000;
    step = longint'(p) + step;
    if (step < 0) step = 0;
    if (step > 64'hFFFF_FFFF) step = 64'hFFFF_FFFF;
    return step[PRICE_W-1:0];
  endfunction

  // Runs a series of random length; now and then the start flag is left off
  // so that a series simply continues, or raised in the middle as noise.
  task automatic random_series(int unsigned len);
    logic [PRICE_W-1:0] p;
    p = ($urandom_range(3) == 0) ? $urandom() : {16'($urandom_range(20, 400)), 16'($urandom())};
    for (int unsigned i = 0; i < len; i++) begin
      send_price(i == 0 ? ($urandom_range(9) != 0) : ($urandom_range(199) == 0), p);
      p = next_price(p);
    end
  endtask

  task automatic random_phase(int unsigned n_items);
    int unsigned stop_at;
    int unsigned len;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(4) == 0)
        set_periods($urandom_range(0, 70), $urandom_range(0, 70), $urandom_range(0, 70));
      len = $urandom_range(5, 90);
      if (len > stop_at - items_sent) len = stop_at - items_sent;
      random_series(len);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: smallest periods, field extremes and a zero close with
    // the series ready, then a fast period above the slow one, clamped to it.
    set_periods(1, 1, 1);
    send_price(1'b1, '0);
    send_price(1'b0, 32'h0001_0000);
    send_price(1'b0, '1);
    send_price(1'b0, '0);
    send_price(1'b0, 32'h0000_0001);
    send_price(1'b0, '1);
    send_price(1'b0, 32'h8000_0000);
    send_price(1'b1, 32'h7FFF_FFFF);
    send_price(1'b0, 32'h5555_AAAA);
    send_price(1'b0, '0);
    set_periods(64, 3, 2);
    for (int i = 0; i < 8; i++) send_price(i == 0, i[0] ? '1 : 32'h0010_0000);
    // Largest periods; the series is not restarted when the change lands.
    set_periods(0, 127, 64);
    for (int i = 0; i < 6; i++) send_price(1'b0, 32'h00C8_0000 + PRICE_W'(i << 16));

    // Random phases with different idling patterns.
    set_periods(12, 26, 9);
    random_phase(400);
    send_idle_pct = 86;
    random_phase(250);
    send_idle_pct = 0;
    recv_stall_pct = 86;
    random_phase(250);
    send_idle_pct = 34;
    recv_stall_pct = 34;
    random_phase(300);

    // Pressure: the receiver holds off while the sender keeps offering.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_receiver = 1'b1;
        repeat (900) @(posedge clk);
        hold_receiver = 1'b0;
      end
      random_phase(20);
    join

    set_periods(2, 5, 3);
    random_phase(450);

    wait_drained();
    repeat (400) @(posedge clk);
    $display("Sent %0d prices in %0d series, checked %0d results, periods 1..64 and out of range.",
             items_sent, series_count, result_count);
    if (fail_count == 0) begin
      $display("** macd_crossover_tracker_core: PASSED **");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("** macd_crossover_tracker_core: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/macd_pkg.sv
sv/macd_div.sv
sv/macd_crossover_tracker_core.sv
sv/macd_checker.sv
verif/macd_tracker_checker.sv
verif/tb_macd_crossover_tracker_core.sv
